@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator: field widths,
// status and operation codes, register indexes and channel payloads.
// ----------------------------------------------------------------------------
package bpa_pkg;

   // Bitmap storage is organised as 64-bit words
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned BIT_W     = 6;

   // Field widths
   localparam int unsigned CNT_W    = 11;
   localparam int unsigned SIZE_W   = 41;
   localparam int unsigned ADDR_W   = 48;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SHIFT_W  = 5;

   // Page size shifts: 2 MiB and 1 GiB
   localparam logic [SHIFT_W-1:0] SHIFT_2M = 5'd21;
   localparam logic [SHIFT_W-1:0] SHIFT_1G = 5'd30;

   // Operation codes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE        = 2'd2;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_ZERO_SIZE    = 3'd1,
      STATUS_NO_SPACE     = 3'd2,
      STATUS_OUTSIDE_POOL = 3'd3,
      STATUS_ALREADY_FREE = 3'd4
   } status_type;

   typedef struct packed {
      logic                opcode;
      logic [SIZE_W-1:0]   request_size;
      logic [ADDR_W-1:0]   release_address;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted_address;
      logic [CNT_W-1:0]    free_page_count;
   } rsp_payload_type;

   // Outcome of looking for a free page in one bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } scan_result_type;

endpackage

@@ rtl/bpa_stream_if.sv @@
// ----------------------------------------------------------------------------
// bpa_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface bpa_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bpa_word_scan.sv @@
// ----------------------------------------------------------------------------
// bpa_word_scan
// Finds the lowest free page in one bitmap word, restricted to the pages
// that the mask admits.
// ----------------------------------------------------------------------------
module bpa_word_scan (
   input  logic [bpa_pkg::WORD_BITS-1:0] used_word,
   input  logic [bpa_pkg::WORD_BITS-1:0] pool_mask,
   output bpa_pkg::scan_result_type      result
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] candidates;

   assign candidates = ~used_word & pool_mask;

   // Priority encode, lowest bit wins
   always_comb begin
      result.found   = |candidates;
      result.bit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (candidates[i]) begin
            result.bit_idx = BIT_W'(i);
         end
      end
   end

endmodule

@@ rtl/bitmap_page_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// First-fit allocator of fixed-size pages over a used-page bitmap held in a
// RAM of 64-bit words.
// ----------------------------------------------------------------------------
// Allocate: decode, a first-free search reading W bitmap words (one per
//   cycle, at most ceil(pool pages / 64), 16 for 1024 pages), result.
// Release: decode, bit check and clear, result; outside the pool, no check.
// One item at a time; a result may wait in the output register while the
//   next item is accepted.
// Reset: synchronous; a clearing pass zeroes the ceil(MAX_PAGES / 64)
//   bitmap words before the first item is accepted.
module bitmap_page_allocator_top #(
   parameter int unsigned MAX_PAGES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   bpa_stream_if.sink                       req_stream,
   bpa_stream_if.source                     rsp_stream,
   input  logic                             csr_write_enable,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bpa_pkg::*;

   localparam int unsigned MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned PW        = AW + BIT_W;
   localparam int unsigned LIMIT_INT = (MAX_PAGES > 2047) ? 2047 : MAX_PAGES;
   localparam int unsigned CMP_W     = (AW > CNT_W) ? AW : CNT_W;
   localparam logic [CNT_W-1:0] MAX_LIMIT  = CNT_W'(LIMIT_INT);
   localparam logic [AW-1:0]    LAST_MAP_W = AW'(MAP_WORDS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_REL_CHK,
      ST_RESP
   } state_type;

   // Configuration registers
   logic                page_size_select_ff;
   logic [CNT_W-1:0]    page_count_ff;
   logic [ADDR_W-1:0]   pool_base_ff;

   // Control and working registers
   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic                op_ff, op_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [AW-1:0]       word_ff, word_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [PW-1:0]       idx_ff, idx_in;
   status_type          status_ff, status_in;
   logic                grant_ff, grant_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   // RAM port signals
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // Derived values
   logic [CNT_W-1:0]     limit;
   logic [CNT_W-1:0]     limit_m1;
   logic [CNT_W-1:0]     free_count;
   logic [SHIFT_W-1:0]   shift;
   logic [SIZE_W-1:0]    size_pages;
   logic [SIZE_W-1:0]    size_rem_mask;
   logic [SIZE_W-1:0]    req_page_total;
   logic                 rel_below;
   logic [ADDR_W-1:0]    rel_offset;
   logic [ADDR_W-1:0]    rel_page;
   logic                 rel_outside;
   logic [PW-1:0]        rel_idx;
   logic [CMP_W-1:0]     scan_ext;
   logic [CMP_W-1:0]     lim_word_ext;
   logic [CMP_W-1:0]     last_word_ext;
   logic [WORD_BITS-1:0] pool_mask;
   logic [ADDR_W-1:0]    grant_offset;
   logic [ADDR_W-1:0]    granted;
   scan_result_type      scan_result;

   // Hold configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_select_ff <= 1'b0;
         page_count_ff       <= '0;
         pool_base_ff        <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PAGE_SIZE_SELECT: page_size_select_ff <= csr_write_data[0];
            CSR_PAGE_COUNT:       page_count_ff       <= csr_write_data[CNT_W-1:0];
            CSR_POOL_BASE:        pool_base_ff        <= csr_write_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // Pool size, page shift and free pages
   assign limit      = (page_count_ff > MAX_LIMIT) ? MAX_LIMIT : page_count_ff;
   assign limit_m1   = limit - CNT_W'(1);
   assign shift      = page_size_select_ff ? SHIFT_1G : SHIFT_2M;
   assign free_count = (limit > used_ff) ? (limit - used_ff) : '0;

   // Round the requested size up to whole pages
   assign size_pages     = size_ff >> shift;
   assign size_rem_mask  = (SIZE_W'(1) << shift) - SIZE_W'(1);
   assign req_page_total = size_pages + SIZE_W'(|(size_ff & size_rem_mask));

   // Locate the page named by a release address
   assign rel_below   = addr_ff < pool_base_ff;
   assign rel_offset  = addr_ff - pool_base_ff;
   assign rel_page    = rel_offset >> shift;
   assign rel_outside = rel_below || (rel_page >= ADDR_W'(limit));
   assign rel_idx     = rel_page[PW-1:0];

   // Admit only pages inside the pool in the word under scan
   assign scan_ext      = CMP_W'(scan_ff);
   assign lim_word_ext  = CMP_W'(limit[CNT_W-1:BIT_W]);
   assign last_word_ext = CMP_W'(limit_m1[CNT_W-1:BIT_W]);
   always_comb begin
      if (scan_ext < lim_word_ext) begin
         pool_mask = '1;
      end else if (scan_ext == lim_word_ext) begin
         pool_mask = (WORD_BITS'(1) << limit[BIT_W-1:0]) - WORD_BITS'(1);
      end else begin
         pool_mask = '0;
      end
   end

   // Address of the granted page
   assign grant_offset = ADDR_W'(idx_ff) << shift;
   assign granted      = pool_base_ff + grant_offset;

   bpa_word_scan u_word_scan (
      .used_word (ram_rd_data),
      .pool_mask (pool_mask),
      .result    (scan_result)
   );

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stream.ready   = (state_ff == ST_IDLE);
   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_payload_ff;

   // Clear the bitmap after reset, then sequence one item: decode, bitmap read-modify-write, result
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      scan_in        = scan_ff;
      used_in        = used_ff;
      op_in          = op_ff;
      size_in        = size_ff;
      addr_in        = addr_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      grant_in       = grant_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_stream.ready;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = scan_ff;
      ram_wr_data    = '0;
      ram_rd_addr    = scan_ff + AW'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            if (clr_ff == LAST_MAP_W) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_stream.valid) begin
               op_in    = req_stream.payload.opcode;
               size_in  = req_stream.payload.request_size;
               addr_in  = req_stream.payload.release_address;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            grant_in = 1'b0;
            if (op_ff == OP_ALLOC) begin
               if (size_ff == '0) begin
                  status_in = STATUS_ZERO_SIZE;
                  state_in  = ST_RESP;
               end else if (free_count == '0 ||
                            req_page_total > SIZE_W'(free_count)) begin
                  status_in = STATUS_NO_SPACE;
                  state_in  = ST_RESP;
               end else begin
                  ram_rd_addr = '0;
                  scan_in     = '0;
                  state_in    = ST_SCAN;
               end
            end else begin
               if (rel_outside) begin
                  status_in = STATUS_OUTSIDE_POOL;
                  state_in  = ST_RESP;
               end else begin
                  ram_rd_addr = rel_idx[PW-1:BIT_W];
                  word_in     = rel_idx[PW-1:BIT_W];
                  bit_in      = rel_idx[BIT_W-1:0];
                  state_in    = ST_REL_CHK;
               end
            end
         end

         ST_SCAN: begin
            // The next word is already being read while this one is checked
            if (scan_result.found) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = scan_ff;
               ram_wr_data = ram_rd_data | (WORD_BITS'(1) << scan_result.bit_idx);
               idx_in      = {scan_ff, scan_result.bit_idx};
               used_in     = used_ff + CNT_W'(1);
               status_in   = STATUS_OK;
               grant_in    = 1'b1;
               state_in    = ST_RESP;
            end else if (scan_ext == last_word_ext || scan_ff == LAST_MAP_W) begin
               status_in = STATUS_NO_SPACE;
               state_in  = ST_RESP;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end

         ST_REL_CHK: begin
            if (!ram_rd_data[bit_ff]) begin
               status_in = STATUS_ALREADY_FREE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = word_ff;
               ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << bit_ff);
               if (used_ff != '0) begin
                  used_in = used_ff - CNT_W'(1);
               end
               status_in = STATUS_OK;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_stream.ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.status          = status_ff;
               rsp_payload_in.granted_address = grant_ff ? granted : '0;
               rsp_payload_in.free_page_count = free_count;
               state_in                       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff        <= scan_in;
      op_ff          <= op_in;
      size_ff        <= size_in;
      addr_ff        <= addr_in;
      word_ff        <= word_in;
      bit_ff         <= bit_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      grant_ff       <= grant_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

@@ tb/bitmap_page_allocator_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top_test
// Self-checking bench for the first-fit page allocator. A scoreboard keeps its
// own copy of the used-page map and settings, works out the reply to every
// accepted item and checks each reply as it leaves the block. Directed items
// cover the corner cases, then randomised phases run under several pool
// settings with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top_test;
   import bpa_pkg::*;

   localparam int unsigned POOL_CAP    = 1024;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned MAX_PRINTED = 40;

   // Scoreboard: own model of the page map, queue of replies still awaited
   class page_pool_scoreboard;
      bit                page_in_use [POOL_CAP];
      int unsigned       pages_in_use;
      logic              gig_pages;
      logic [CNT_W-1:0]  page_limit;
      logic [ADDR_W-1:0] base_addr;
      rsp_payload_type   awaited_replies [$];
      int unsigned       error_count;

      function new();
         pages_in_use = 0;
         gig_pages    = 1'b0;
         page_limit   = '0;
         base_addr    = '0;
         error_count  = 0;
         foreach (page_in_use[i]) page_in_use[i] = 1'b0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PAGE_SIZE_SELECT: gig_pages  = data[0];
            CSR_PAGE_COUNT:       page_limit = data[CNT_W-1:0];
            CSR_POOL_BASE:        base_addr  = data[ADDR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pool_size();
         return (page_limit > POOL_CAP) ? POOL_CAP : int'(page_limit);
      endfunction

      function int unsigned free_total();
         int unsigned span;
         span = pool_size();
         return (span > pages_in_use) ? span - pages_in_use : 0;
      endfunction

      function int unsigned shift_amount();
         return gig_pages ? 30 : 21;
      endfunction

      // Work out the reply to an accepted item and queue it
      function void note_request(req_payload_type item);
         rsp_payload_type reply;
         int unsigned     sh;
         int unsigned     span;
         int unsigned     avail;
         int unsigned     slot;
         logic [63:0]     size;
         logic [63:0]     pages;
         logic [63:0]     idx;
         logic [63:0]     grant;
         sh    = shift_amount();
         span  = pool_size();
         reply = '0;
         reply.status = STATUS_OK;
         if (item.opcode == OP_ALLOC) begin
            size  = 64'(item.request_size);
            pages = (size >> sh) + ((size & ((64'd1 << sh) - 64'd1)) != 0 ? 64'd1 : 64'd0);
            avail = free_total();
            if (size == 0) begin
               reply.status = STATUS_ZERO_SIZE;
            end else if (avail == 0 || pages > 64'(avail)) begin
               reply.status = STATUS_NO_SPACE;
            end else begin
               // first fit: lowest clear bit inside the pool
               slot = span;
               for (int unsigned i = 0; i < span; i++) begin
                  if (!page_in_use[i] && slot == span) slot = i;
               end
               if (slot >= span) begin
                  reply.status = STATUS_NO_SPACE;
               end else begin
                  page_in_use[slot] = 1'b1;
                  pages_in_use++;
                  grant = 64'(base_addr) + (64'(slot) << sh);
                  reply.granted_address = grant[ADDR_W-1:0];
               end
            end
         end else begin
            if (item.release_address < base_addr) begin
               reply.status = STATUS_OUTSIDE_POOL;
            end else begin
               idx = 64'(item.release_address - base_addr) >> sh;
               if (idx >= 64'(span)) begin
                  reply.status = STATUS_OUTSIDE_POOL;
               end else if (!page_in_use[idx]) begin
                  reply.status = STATUS_ALREADY_FREE;
               end else begin
                  page_in_use[idx] = 1'b0;
                  if (pages_in_use > 0) pages_in_use--;
               end
            end
         end
         reply.free_page_count = free_total();
         awaited_replies.push_back(reply);
      endfunction

      task report(string msg);
         if (error_count < MAX_PRINTED) $display("mismatch: %s", msg);
         error_count++;
      endtask

      // Compare a reply with the oldest one awaited
      task check_reply(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_replies.size() == 0) begin
            report("reply arrived with nothing awaited");
         end else begin
            want = awaited_replies.pop_front();
            if (got.status !== want.status)
               report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.granted_address !== want.granted_address)
               report($sformatf("granted_address got %h want %h",
                                got.granted_address, want.granted_address));
            if (got.free_page_count !== want.free_page_count)
               report($sformatf("free_page_count got %0d want %0d",
                                got.free_page_count, want.free_page_count));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   bpa_stream_if #(.payload_type(req_payload_type)) req_if ();
   bpa_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   page_pool_scoreboard sb;
   int unsigned         items_sent;
   int unsigned         cycle_count;
   bit                  steady_flow;
   logic                hold_off;

   bitmap_page_allocator_top #(.MAX_PAGES(POOL_CAP)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_draw();
      return steady_flow ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic req_payload_type make_alloc(logic [63:0] size);
      req_payload_type item;
      item.opcode          = OP_ALLOC;
      item.request_size    = size[SIZE_W-1:0];
      item.release_address = {16'($urandom), $urandom};
      return item;
   endfunction

   function automatic req_payload_type make_release(logic [63:0] addr);
      req_payload_type item;
      item.opcode          = OP_RELEASE;
      item.request_size    = {1'b0, 8'($urandom), $urandom};
      item.release_address = addr[ADDR_W-1:0];
      return item;
   endfunction

   // Mostly well-formed items aimed at the pool, with some noise
   function automatic req_payload_type random_request(int unsigned alloc_pct);
      int unsigned sh;
      int unsigned span;
      int unsigned pick;
      logic [63:0] page_mask;
      logic [63:0] value;
      sh        = sb.shift_amount();
      span      = sb.pool_size();
      pick      = $urandom_range(0, 99);
      page_mask = (64'd1 << sh) - 64'd1;
      if (sb.free_total() == 0) alloc_pct = 30;
      if ($urandom_range(0, 99) < alloc_pct) begin
         if (pick < 4)
            value = 64'd0;
         else if (pick < 10)
            value = {24'd0, 8'($urandom), $urandom};
         else if (pick < 12)
            value = 64'd1 << 40;
         else begin
            value = (64'($urandom_range(0, 3)) << sh) + (64'($urandom) & page_mask);
            if (value == 0) value = 64'd1;
         end
         return make_alloc(value);
      end
      if (pick < 10)
         value = {16'd0, 16'($urandom), $urandom};
      else if (pick < 15 && sb.base_addr != 0)
         value = 64'(sb.base_addr) - 64'd1 - 64'($urandom_range(0, 1000));
      else
         value = 64'(sb.base_addr) + (64'($urandom_range(0, span + 1)) << sh)
                 + (64'($urandom) & page_mask);
      return make_release(value);
   endfunction

   // Offer one item after a random gap and hold it until taken
   task automatic send_request(req_payload_type item);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(item);
      items_sent++;
   endtask

   // Drop valid and wait until every awaited reply has left the block
   task automatic drain_outstanding(int unsigned tail);
      req_if.valid <= 1'b0;
      while (sb.awaited_replies.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Write all three registers, one per cycle
   task automatic write_settings(logic size_sel, logic [CNT_W-1:0] pages,
                                 logic [ADDR_W-1:0] base);
      logic [CSR_IDX_W-1:0]  idx   [3];
      logic [CSR_DATA_W-1:0] value [3];
      int                    k;
      idx[0]   = CSR_PAGE_SIZE_SELECT;
      idx[1]   = CSR_PAGE_COUNT;
      idx[2]   = CSR_POOL_BASE;
      value[0] = CSR_DATA_W'(size_sel);
      value[1] = CSR_DATA_W'(pages);
      value[2] = CSR_DATA_W'(base);
      for (k = 0; k < 3; k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[k];
         csr_write_data   <= value[k];
         @(posedge clock);
         sb.write_register(idx[k], value[k]);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(logic size_sel, logic [CNT_W-1:0] pages, logic [ADDR_W-1:0] base,
                            int unsigned count, int unsigned alloc_pct);
      int unsigned k;
      drain_outstanding(8);
      write_settings(size_sel, pages, base);
      for (k = 0; k < count; k++) begin
         steady_flow = ((k / 32) % 4) == 3;
         send_request(random_request(alloc_pct));
      end
   endtask

   // Reply side: random stall per item, long hold-off on request, check on take
   initial begin
      int stall_left;
      rsp_if.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_reply(rsp_if.payload);
            stall_left = idle_draw();
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_if.ready <= !reset && !hold_off && stall_left == 0;
      end
   end

   // Hold the reply side off for a long stretch so the block backs up
   initial begin
      hold_off <= 1'b0;
      while (items_sent < 350) @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Give up if the run hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[bitmap_page_allocator_top] ERROR");
      $finish;
   end

   // Main sequence
   initial begin
      logic [63:0] dir_base;
      logic [63:0] pg;
      sb               = new();
      items_sent       = 0;
      steady_flow      = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.payload   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Four 2 MiB pages above 4 GiB: sizes, fill, pool edges, double release
      dir_base = 64'h1_0000_0000;
      pg       = 64'h20_0000;
      write_settings(1'b0, 11'd4, dir_base[ADDR_W-1:0]);
      send_request(make_alloc(64'd0));
      send_request(make_alloc(64'd1));
      send_request(make_alloc(64'd1 << 40));
      send_request(make_alloc(3 * pg));
      send_request(make_alloc(3 * pg + 1));
      send_request(make_alloc(pg));
      send_request(make_alloc(64'd5));
      send_request(make_alloc(64'd1));
      send_request(make_release(dir_base - 1));
      send_request(make_release(dir_base + 4 * pg));
      send_request(make_release(dir_base + pg + 64'h1F_FFFF));
      send_request(make_release(dir_base + pg));
      send_request(make_alloc(64'd1));
      send_request(make_release(64'hFFFF_FFFF_FFFF));
      send_request(make_release(64'd0));

      // Shrink the pool below the pages in use
      drain_outstanding(8);
      write_settings(1'b0, 11'd2, dir_base[ADDR_W-1:0]);
      send_request(make_alloc(64'd1));
      send_request(make_release(dir_base + 3 * pg));
      send_request(make_release(dir_base));

      // Switch to 1 GiB pages at base zero with the map kept
      drain_outstanding(8);
      write_settings(1'b1, 11'd4, 48'd0);
      send_request(make_release(64'd0));
      send_request(make_release((64'd1 << 30) + 5));
      send_request(make_alloc(64'd1));
      send_request(make_release(64'd3 << 30));
      send_request(make_alloc((64'd1 << 30) + 1));

      // Empty pool
      drain_outstanding(8);
      write_settings(1'b0, 11'd0, 48'd0);
      send_request(make_alloc(64'd1));
      send_request(make_release(64'd0));

      // Randomised phases over a spread of pool settings
      run_phase(1'b0, 11'd16,   48'h0000_4000_0000, 190, 55);
      run_phase(1'b1, 11'd64,   48'hFFFF_C000_0000, 150, 55);
      run_phase(1'b0, 11'd1024, 48'h0123_4560_0000, 200, 75);
      run_phase(1'b1, 11'd1,    48'd0,               80, 50);
      run_phase(1'b0, 11'd0,    48'h0000_0020_0000,  30, 50);
      run_phase(1'b1, 11'd200,  {16'($urandom), 2'($urandom), 30'd0}, 200, 55);
      run_phase(1'b0, 11'd7,    48'hFFFF_FFFF_FFFF, 100, 55);

      drain_outstanding(50);
      if (sb.error_count == 0) begin
         $display("[bitmap_page_allocator_top] OK");
      end else begin
         $display("[bitmap_page_allocator_top] ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bpa_pkg.sv
rtl/bpa_stream_if.sv
rtl/bpa_ram.sv
rtl/bpa_word_scan.sv
rtl/bitmap_page_allocator_top.sv
tb/bitmap_page_allocator_top_test.sv
